FILE: design/magnetometer_frame_checker_core_defines.svh
// Assertion macros shared by the frame checker modules.
`ifndef MAGNETOMETER_FRAME_CHECKER_CORE_DEFINES_SVH
`define MAGNETOMETER_FRAME_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define MFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante |-> cons");

// Next-cycle implication, disabled while reset is low.
`define MFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

`endif

FILE: design/mfc_pkg.sv
`default_nettype none

package mfc_pkg;

    localparam int IN_FIELDS_W  = 97;
    localparam int OUT_FIELDS_W = 90;
    localparam int IN_W         = 104;
    localparam int OUT_W        = 96;
    localparam int CRC_MSG_W    = 80;

    localparam logic [7:0] CRC_POLY     = 8'h07;
    localparam logic [3:0] MAX_ATT_RST  = 4'd5;

    // error flag bit positions
    localparam int FLAG_OVF  = 0;
    localparam int FLAG_COMM = 1;
    localparam int FLAG_NRDY = 2;
    localparam int FLAG_CNT  = 3;
    localparam int FLAG_CRC  = 4;
    localparam int FLAG_BUS  = 5;
    localparam int FLAG_W    = 6;

    // status byte bit positions
    localparam int ST_CNT0  = 0;
    localparam int ST_DRDY  = 1;
    localparam int ST_OVF   = 3;
    localparam int ST_CE    = 4;
    localparam int ST_CNT1  = 5;
    localparam int ST_CNT2  = 6;
    localparam int ST_BURST = 7;

    typedef enum logic [1:0] {
        CFG_SWAP_X  = 2'd0,
        CFG_SWAP_Y  = 2'd1,
        CFG_SWAP_Z  = 2'd2,
        CFG_MAX_ATT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic       swap_x;
        logic       swap_y;
        logic       swap_z;
        logic [3:0] retry_limit;
    } t_cfg;

    // classified frame handed from front to back
    typedef struct packed {
        logic        bus_ok;
        logic        ovf;
        logic        comm;
        logic        nrdy;
        logic        burst;
        logic [2:0]  cnt;
        logic        crc_ok;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [15:0] temp;
        logic [15:0] volt;
    } t_cls;

    // CRC contribution of one message bit, pos counted from the last bit sent
    function automatic logic [7:0] crc_col(int unsigned pos);
        logic [7:0] r;
        r = 8'h01;
        for (int unsigned k = 0; k < pos + 8; k++) begin
            r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    // CRC-8 as an XOR of per-bit columns; the columns fold to constants
    function automatic logic [7:0] crc_calc(logic [CRC_MSG_W-1:0] msg);
        logic [7:0] c;
        c = '0;
        for (int i = 0; i < CRC_MSG_W; i++) begin
            if (msg[i]) begin
                c = c ^ crc_col(i);
            end
        end
        return c;
    endfunction

    function automatic logic [15:0] neg_sat(logic [15:0] v);
        if (v == 16'h8000) begin
            return 16'h7fff;
        end
        return (~v) + 16'd1;
    endfunction

endpackage

`default_nettype wire

FILE: design/magnetometer_frame_checker_core.sv
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   one read frame (bus ok, status, crc, 5 words)
// m_axis    out  m_axis_tvalid/m_axis_tready   check result and held values
// cfg       in   i_cfg_we                      swap_x/y/z sign, retry limit
//
// One frame per cycle sustained while m_axis_tready stays high. A frame accepted
// is classified and written to the queue; the back end pops it from the queue into
// the output register once that register is empty or being taken. CRC and sign
// handling sit in the front, the retry and held-value state in the back. Reset
// clears the queue, the output valid, all held state and loads the retry limit with
// 5. An output stall fills the QUEUE_DEPTH-entry queue, after which s_axis_tready drops.
`default_nettype none

module magnetometer_frame_checker_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // bus_ok, status_byte, frame_crc, x_raw, y_raw, z_raw, temp_raw, volt_raw
    input  wire logic [mfc_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // error_flags, error_reported, reinit_request, data_updated, x_value,
    // y_value, z_value, temp_value, volt_value, burst_mode
    output logic [mfc_pkg::OUT_W-1:0]       m_axis_tdata,
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_addr,
    input  wire logic [3:0]                 i_cfg_wdata
);
    import mfc_pkg::*;

    t_cfg r_cfg;
    t_cls front_cls;
    t_cls queue_cls;
    logic push;
    logic queue_valid;
    logic queue_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.swap_x      <= 1'b0;
            r_cfg.swap_y      <= 1'b0;
            r_cfg.swap_z      <= 1'b0;
            r_cfg.retry_limit <= MAX_ATT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_SWAP_X:  r_cfg.swap_x      <= i_cfg_wdata[0];
                CFG_SWAP_Y:  r_cfg.swap_y      <= i_cfg_wdata[0];
                CFG_SWAP_Z:  r_cfg.swap_z      <= i_cfg_wdata[0];
                CFG_MAX_ATT: r_cfg.retry_limit <= i_cfg_wdata;
            endcase
        end
    end

    assign push = s_axis_tvalid && s_axis_tready;

    mfc_front u_front (
        .i_frame (s_axis_tdata[IN_FIELDS_W-1:0]),
        .i_cfg   (r_cfg),
        .o_cls   (front_cls)
    );

    mfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .o_ready (s_axis_tready),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_data  (queue_cls)
    );

    mfc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_retry_limit (r_cfg.retry_limit),
        .i_cls_valid   (queue_valid),
        .i_cls         (queue_cls),
        .o_cls_pop     (queue_pop),
        .o_tvalid      (m_axis_tvalid),
        .i_tready      (m_axis_tready),
        .o_tdata       (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: design/mfc_front.sv
`default_nettype none

module mfc_front (
    input  wire logic [mfc_pkg::IN_FIELDS_W-1:0] i_frame,    // bus_ok, status, crc, x, y, z, temp, volt
    input  wire mfc_pkg::t_cfg                   i_cfg,
    output mfc_pkg::t_cls                        o_cls
);
    import mfc_pkg::*;

    logic [7:0]  status;
    logic [7:0]  rx_crc;
    logic [15:0] x_raw, y_raw, z_raw, temp_raw, volt_raw;

    assign status   = i_frame[8:1];
    assign rx_crc   = i_frame[16:9];
    assign x_raw    = i_frame[32:17];
    assign y_raw    = i_frame[48:33];
    assign z_raw    = i_frame[64:49];
    assign temp_raw = i_frame[80:65];
    assign volt_raw = i_frame[96:81];

    always_comb begin
        o_cls.bus_ok = i_frame[0];
        o_cls.ovf    = status[ST_OVF];
        o_cls.comm   = status[ST_CE];
        o_cls.nrdy   = !status[ST_DRDY];
        o_cls.burst  = status[ST_BURST];
        o_cls.cnt    = {status[ST_CNT2], status[ST_CNT1], status[ST_CNT0]};
        // words go out high byte first, x first
        o_cls.crc_ok = (crc_calc({x_raw, y_raw, z_raw, temp_raw, volt_raw}) == rx_crc);
        o_cls.x      = i_cfg.swap_x ? neg_sat(x_raw) : x_raw;
        o_cls.y      = i_cfg.swap_y ? neg_sat(y_raw) : y_raw;
        o_cls.z      = i_cfg.swap_z ? neg_sat(z_raw) : z_raw;
        o_cls.temp   = temp_raw;
        o_cls.volt   = volt_raw;
    end

endmodule

`default_nettype wire

FILE: design/mfc_queue.sv
`default_nettype none

`include "magnetometer_frame_checker_core_defines.svh"

module mfc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire mfc_pkg::t_cls i_data,
    output logic               o_ready,
    input  wire logic          i_pop,
    output logic               o_valid,
    output mfc_pkg::t_cls      o_data
);
    import mfc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cls             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `MFC_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, r_count == CNT_W'(DEPTH), !i_push)
    `MFC_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, r_count == '0, !i_pop)

endmodule

`default_nettype wire

FILE: design/mfc_back.sv
`default_nettype none

`include "magnetometer_frame_checker_core_defines.svh"

module mfc_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [3:0]                 i_retry_limit,
    input  wire logic                       i_cls_valid,
    input  wire mfc_pkg::t_cls              i_cls,
    output logic                            o_cls_pop,
    output logic                            o_tvalid,
    input  wire logic                       i_tready,
    // flags, reported, reinit, updated, x, y, z, temp, volt, burst
    output logic [mfc_pkg::OUT_W-1:0]       o_tdata
);
    import mfc_pkg::*;

    logic              r_out_valid;
    logic [FLAG_W-1:0] r_flags;
    logic              r_reported, r_reinit, r_updated;
    logic [2:0]        r_last_cnt, n_last_cnt;
    logic [3:0]        r_retry, n_retry;
    logic [15:0]       r_x, r_y, r_z, r_temp, r_volt;
    logic              r_burst, n_burst;

    logic [FLAG_W-1:0] n_flags;
    logic              n_reported, n_reinit, n_updated;
    logic              fatal;
    logic [FLAG_W-1:0] hide_mask;

    assign o_cls_pop = i_cls_valid && (!r_out_valid || i_tready);
    assign o_tvalid  = r_out_valid;
    assign o_tdata   = {{(OUT_W - OUT_FIELDS_W){1'b0}}, r_burst, r_volt, r_temp, r_z, r_y, r_x,
                        r_updated, r_reinit, r_reported, r_flags};

    always_comb begin
        hide_mask            = '1;
        hide_mask[FLAG_NRDY] = 1'b0;
        hide_mask[FLAG_CNT]  = 1'b0;

        fatal      = i_cls.ovf || i_cls.comm;
        n_flags    = '0;
        n_last_cnt = r_last_cnt;
        n_burst    = r_burst;
        n_updated  = 1'b0;
        n_reported = 1'b0;
        n_reinit   = 1'b0;
        n_retry    = r_retry;

        if (!i_cls.bus_ok) begin
            n_flags[FLAG_BUS] = 1'b1;
        end else begin
            n_burst            = i_cls.burst;
            n_flags[FLAG_OVF]  = i_cls.ovf;
            n_flags[FLAG_COMM] = i_cls.comm;
            if (!fatal) begin
                n_flags[FLAG_NRDY] = i_cls.nrdy;
                if (i_cls.burst) begin
                    if (i_cls.cnt == r_last_cnt) begin
                        n_flags[FLAG_CNT] = 1'b1;
                    end else begin
                        n_last_cnt = i_cls.cnt;
                    end
                end
                n_flags[FLAG_CRC] = !i_cls.crc_ok;
                n_updated         = i_cls.crc_ok;
            end
        end

        if (n_flags != '0) begin
            n_reported = 1'b1;
            if (r_retry >= i_retry_limit) begin
                n_reinit = 1'b1;
                n_retry  = '0;
            end else begin
                n_retry = r_retry + 4'd1;
                // hide a lone soft error
                if (r_retry == '0 && (n_flags & hide_mask) == '0) begin
                    n_reported = 1'b0;
                end
            end
        end else begin
            n_retry = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_last_cnt  <= '0;
            r_retry     <= '0;
            r_burst     <= 1'b0;
            r_x         <= '0;
            r_y         <= '0;
            r_z         <= '0;
            r_temp      <= '0;
            r_volt      <= '0;
        end else begin
            if (o_cls_pop) begin
                r_out_valid <= 1'b1;
                r_last_cnt  <= n_last_cnt;
                r_retry     <= n_retry;
                r_burst     <= n_burst;
                if (n_updated) begin
                    r_x    <= i_cls.x;
                    r_y    <= i_cls.y;
                    r_z    <= i_cls.z;
                    r_temp <= i_cls.temp;
                    r_volt <= i_cls.volt;
                end
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cls_pop) begin
            r_flags    <= n_flags;
            r_reported <= n_reported;
            r_reinit   <= n_reinit;
            r_updated  <= n_updated;
        end
    end

    `MFC_ASSERT_IMP(a_reinit_reported, i_clk, i_rst_n, r_out_valid && r_reinit, r_reported && (r_flags != '0))
    `MFC_ASSERT_IMP(a_update_clean, i_clk, i_rst_n, r_out_valid && r_updated, (r_flags & hide_mask) == '0)
    `MFC_ASSERT_NXT(a_reinit_clears, i_clk, i_rst_n, o_cls_pop && n_reinit, r_retry == '0)

endmodule

`default_nettype wire
